// ===== rtl/orem_pkg.sv =====
// Shared types, constants and helper functions for the oscillator residual error metrics block.
package orem_pkg;

  // Default configuration of the datapath.
  localparam int unsigned SAMPLE_BITS_DEF      = 32;
  localparam int unsigned FRAC_BITS_DEF        = 16;
  localparam int unsigned LOG2_MAX_SAMPLES_DEF = 16;

  // 2*pi and 4*pi^2 with 32 fraction bits; rounded to the nearest FRAC_BITS value at elaboration.
  localparam logic [63:0] TWO_PI_Q32     = 64'd26986075409;
  localparam logic [63:0] FOUR_PI_SQ_Q32 = 64'd169558512509;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DAMPING      = 2'd0,
    CFG_PERIOD       = 2'd1,
    CFG_SQUARE_COEFF = 2'd2,
    CFG_CUBE_COEFF   = 2'd3
  } cfg_idx_e;

  // Width of the divider step count: 64 numerator bits plus up to 63 extra fraction bits.
  localparam int unsigned STEP_W = 7;

  typedef struct packed {
    logic              start;
    logic [63:0]       num;
    logic [63:0]       den;
    logic [STEP_W-1:0] frac_steps;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [63:0] quo;
  } div_rsp_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    logic [63:0] m;
    m = x[63] ? (64'd0 - 64'(x)) : 64'(x);
    return m;
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

endpackage

// ===== rtl/oscillator_residual_error_metrics.sv =====
// Top level of the oscillator residual error metrics block: sequencer, sums and result register.
//
// Usage: one request on the input channel carries one sample of the model
// output (acceleration, velocity, displacement, its square and cube) and the
// recorded calibration sample. The block scores the residual of the oscillator
// equation and keeps four saturating sums. The request flagged last_sample
// ends the run and produces one result request: the mean deviation ratio, the
// RMS ratio and a zero-denominator flag; all other samples produce nothing.
// Configuration registers (damping, period, c0, c1) are written over the
// config channel, which is always ready; the user must write them only while the
// block is idle, which the block does not enforce. The gains are latched from
// them on the first sample of each run. Timing: in_stall_o is high whenever a
// sample is being worked on. Each sample takes two multiplier passes and an
// add for each of four products, one pass for each of two squares and two
// adds before the next request. The first sample of a run adds two 64-step
// gain divisions in the serial divider. The last sample adds (64+F) + (64+2F)
// divider steps and 32 square-root steps before the result is registered.
// The result sits in an output register; when the receiver stalls, the block
// holds it there and waits only if a new result is ready behind it.
// Reset clears the sums, the run flag, the output valid and the registers to
// damping 0, period 1.0 and zero coefficients.
module oscillator_residual_error_metrics #(
  parameter int unsigned SAMPLE_BITS      = orem_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS        = orem_pkg::FRAC_BITS_DEF,
  parameter int unsigned LOG2_MAX_SAMPLES = orem_pkg::LOG2_MAX_SAMPLES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Sample channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] accel_i,
  input  logic signed [SAMPLE_BITS-1:0] veloc_i,
  input  logic signed [SAMPLE_BITS-1:0] displ_i,
  input  logic signed [SAMPLE_BITS-1:0] displ_sq_i,
  input  logic signed [SAMPLE_BITS-1:0] displ_cube_i,
  input  logic signed [SAMPLE_BITS-1:0] calib_sample_i,
  input  logic                          last_sample_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [31:0]                   mean_dev_ratio_o,
  output logic [31:0]                   rms_ratio_o,
  output logic                          zero_denominator_o,
  // Configuration channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [orem_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  localparam logic [63:0] RES_MAX = (64'd1 << (64 - LOG2_MAX_SAMPLES)) - 64'd1;
  localparam logic [63:0] C2 =
    (orem_pkg::TWO_PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam logic [63:0] C4 =
    (orem_pkg::FOUR_PI_SQ_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam logic [63:0] DG_NUM = C4 << FRAC_BITS;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_GMUL = 4'd1;
  localparam logic [3:0] ST_GDV  = 4'd2;
  localparam logic [3:0] ST_GW1  = 4'd3;
  localparam logic [3:0] ST_GW2  = 4'd4;
  localparam logic [3:0] ST_MLO  = 4'd5;
  localparam logic [3:0] ST_MHI  = 4'd6;
  localparam logic [3:0] ST_MACC = 4'd7;
  localparam logic [3:0] ST_SQR  = 4'd8;
  localparam logic [3:0] ST_SQC  = 4'd9;
  localparam logic [3:0] ST_ACC  = 4'd10;
  localparam logic [3:0] ST_FIN  = 4'd11;
  localparam logic [3:0] ST_DWM  = 4'd12;
  localparam logic [3:0] ST_DWR  = 4'd13;
  localparam logic [3:0] ST_SQW  = 4'd14;
  localparam logic [3:0] ST_OUT  = 4'd15;

  function automatic logic signed [63:0] clamp_res(input logic signed [63:0] x);
    logic signed [63:0] r;
    if (x > $signed(RES_MAX)) r = $signed(RES_MAX);
    else if (x < -$signed(RES_MAX)) r = -$signed(RES_MAX);
    else r = x;
    return r;
  endfunction

  logic [3:0] state_q, state_d;

  // Configuration registers
  logic [31:0] damping_q, period_q, sq_coeff_q, cube_coeff_q;

  // Run state
  logic        run_active_q;
  logic        last_q;
  logic [31:0] vgain_q, dgain_q;
  logic [1:0]  op_q;
  logic [63:0] samp_mag_q [4];
  logic [3:0]  samp_neg_q;
  logic signed [63:0] r_q;
  logic [63:0] ac_q, ar_q, lo_q;
  logic [63:0] abs_resid_q, sq_resid_q, abs_calib_q, sq_calib_q;
  logic [31:0] mean_q, rms_q;
  logic        zden_q;

  // Output register
  logic        out_valid_q;
  logic [31:0] out_mean_q, out_rms_q;
  logic        out_zden_q;

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;

  // Shared units
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  orem_pkg::div_req_t div_req;
  orem_pkg::div_rsp_t div_rsp;
  logic        div_busy;
  logic        sqrt_start;
  logic [63:0] sqrt_x;
  logic        sqrt_done;
  logic [31:0] sqrt_root;

  orem_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  orem_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp),
    .busy_o (div_busy)
  );

  orem_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .x_i     (sqrt_x),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // Sign-extended view of the incoming sample.
  logic signed [63:0] acc_x, vel_x, dis_x, dsq_x, dcu_x, cal_x, cal_c;
  assign acc_x = 64'(accel_i);
  assign vel_x = 64'(veloc_i);
  assign dis_x = 64'(displ_i);
  assign dsq_x = 64'(displ_sq_i);
  assign dcu_x = 64'(displ_cube_i);
  assign cal_x = 64'(calib_sample_i);
  assign cal_c = clamp_res(cal_x);

  // Gain of the current product term as magnitude and sign.
  logic [31:0] gain_mag;
  logic        gain_neg;
  logic [63:0] samp_mag;
  always_comb begin
    unique case (op_q)
      2'd0: begin
        gain_mag = vgain_q;
        gain_neg = 1'b0;
      end
      2'd1: begin
        gain_mag = dgain_q;
        gain_neg = 1'b0;
      end
      2'd2: begin
        gain_mag = sq_coeff_q[31] ? (32'd0 - sq_coeff_q) : sq_coeff_q;
        gain_neg = sq_coeff_q[31];
      end
      default: begin
        gain_mag = cube_coeff_q[31] ? (32'd0 - cube_coeff_q) : cube_coeff_q;
        gain_neg = cube_coeff_q[31];
      end
    endcase
    samp_mag = samp_mag_q[op_q];
  end

  // Product assembly: lo_q holds gain*low word, mul_p holds gain*high word.
  logic [64:0] prod_sum;
  logic [63:0] prod_sat, prod_shr, prod_clamp;
  logic signed [63:0] term;
  assign prod_sum   = {1'b0, mul_p[31:0], 32'd0} + {1'b0, lo_q};
  assign prod_sat   = ((mul_p[63:32] != '0) || prod_sum[64]) ? '1 : prod_sum[63:0];
  assign prod_shr   = prod_sat >> FRAC_BITS;
  assign prod_clamp = (prod_shr > RES_MAX) ? RES_MAX : prod_shr;
  assign term       = (gain_neg ^ samp_neg_q[op_q]) ? -$signed(prod_clamp)
                                                    : $signed(prod_clamp);

  logic [63:0] ar_c, r_mag;
  assign r_mag = orem_pkg::mag64(r_q);
  assign ar_c  = (r_mag > RES_MAX) ? RES_MAX : r_mag;

  logic [31:0] div_sat32;
  assign div_sat32 = (div_rsp.ovf || (div_rsp.quo[63:32] != '0)) ? '1 : div_rsp.quo[31:0];

  logic sums_zero;
  assign sums_zero = (abs_calib_q == '0) || (sq_calib_q == '0);

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_GMUL: begin
        mul_a = C2[31:0];
        mul_b = damping_q;
      end
      ST_MLO: begin
        mul_a = gain_mag;
        mul_b = samp_mag[31:0];
      end
      ST_MHI: begin
        mul_a = gain_mag;
        mul_b = samp_mag[63:32];
      end
      ST_SQR: begin
        mul_a = ar_c[31:0];
        mul_b = ar_c[31:0];
      end
      ST_SQC: begin
        mul_a = ac_q[31:0];
        mul_b = ac_q[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider and square-root requests.
  always_comb begin
    div_req            = '0;
    sqrt_start         = 1'b0;
    sqrt_x             = div_rsp.ovf ? '1 : div_rsp.quo;
    unique case (state_q)
      ST_GDV: begin
        div_req.start = (period_q != '0);
        div_req.num   = mul_p;
        div_req.den   = 64'(period_q);
      end
      ST_GW1: begin
        div_req.start = div_rsp.done;
        div_req.num   = DG_NUM;
        div_req.den   = 64'(period_q);
      end
      ST_FIN: begin
        div_req.start      = !sums_zero;
        div_req.num        = abs_resid_q;
        div_req.den        = abs_calib_q;
        div_req.frac_steps = orem_pkg::STEP_W'(FRAC_BITS);
      end
      ST_DWM: begin
        div_req.start      = div_rsp.done;
        div_req.num        = sq_resid_q;
        div_req.den        = sq_calib_q;
        div_req.frac_steps = orem_pkg::STEP_W'(2 * FRAC_BITS);
      end
      ST_DWR: begin
        sqrt_start = div_rsp.done;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = run_active_q ? ST_MLO : ST_GMUL;
      ST_GMUL: state_d = ST_GDV;
      ST_GDV:  state_d = (period_q != '0) ? ST_GW1 : ST_MLO;
      ST_GW1:  if (div_rsp.done) state_d = ST_GW2;
      ST_GW2:  if (div_rsp.done) state_d = ST_MLO;
      ST_MLO:  state_d = ST_MHI;
      ST_MHI:  state_d = ST_MACC;
      ST_MACC: state_d = (op_q == 2'd3) ? ST_SQR : ST_MLO;
      ST_SQR:  state_d = ST_SQC;
      ST_SQC:  state_d = ST_ACC;
      ST_ACC:  state_d = last_q ? ST_FIN : ST_IDLE;
      ST_FIN:  state_d = sums_zero ? ST_OUT : ST_DWM;
      ST_DWM:  if (div_rsp.done) state_d = ST_DWR;
      ST_DWR:  if (div_rsp.done) state_d = ST_SQW;
      ST_SQW:  if (sqrt_done) state_d = ST_OUT;
      ST_OUT:  if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      run_active_q <= 1'b0;
      out_valid_q  <= 1'b0;
      op_q         <= '0;
      damping_q    <= '0;
      period_q     <= 32'd1 << FRAC_BITS;
      sq_coeff_q   <= '0;
      cube_coeff_q <= '0;
      abs_resid_q  <= '0;
      sq_resid_q   <= '0;
      abs_calib_q  <= '0;
      sq_calib_q   <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) begin
        unique case (orem_pkg::cfg_idx_e'(cfg_index_i))
          orem_pkg::CFG_DAMPING:      damping_q    <= cfg_data_i;
          orem_pkg::CFG_PERIOD:       period_q     <= cfg_data_i;
          orem_pkg::CFG_SQUARE_COEFF: sq_coeff_q   <= cfg_data_i;
          orem_pkg::CFG_CUBE_COEFF:   cube_coeff_q <= cfg_data_i;
          default:                    damping_q    <= damping_q;
        endcase
      end

      if (in_acc) begin
        run_active_q <= 1'b1;
        op_q         <= '0;
      end
      if (state_q == ST_MACC) op_q <= op_q + 2'd1;

      if (state_q == ST_SQC) begin
        abs_resid_q <= orem_pkg::sat_add64(abs_resid_q, ar_q);
        sq_resid_q  <= orem_pkg::sat_add64(sq_resid_q,
                                           (ar_q[63:32] != '0) ? '1 : mul_p);
      end
      if (state_q == ST_ACC) begin
        abs_calib_q <= orem_pkg::sat_add64(abs_calib_q, ac_q);
        sq_calib_q  <= orem_pkg::sat_add64(sq_calib_q,
                                           (ac_q[63:32] != '0) ? '1 : mul_p);
      end

      // The finished result moves to the output register; the run starts over.
      if (state_q == ST_OUT && (!out_valid_q || !out_stall_i)) begin
        out_valid_q  <= 1'b1;
        run_active_q <= 1'b0;
        abs_resid_q  <= '0;
        sq_resid_q   <= '0;
        abs_calib_q  <= '0;
        sq_calib_q   <= '0;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      last_q        <= last_sample_i;
      r_q           <= clamp_res(acc_x) - cal_c;
      ac_q          <= orem_pkg::mag64(cal_c);
      samp_mag_q[0] <= orem_pkg::mag64(vel_x);
      samp_mag_q[1] <= orem_pkg::mag64(dis_x);
      samp_mag_q[2] <= orem_pkg::mag64(dsq_x);
      samp_mag_q[3] <= orem_pkg::mag64(dcu_x);
      samp_neg_q    <= {dcu_x[63], dsq_x[63], dis_x[63], vel_x[63]};
    end
    if (state_q == ST_GDV && period_q == '0) begin
      vgain_q <= '1;
      dgain_q <= '1;
    end
    if (state_q == ST_GW1 && div_rsp.done) vgain_q <= div_sat32;
    if (state_q == ST_GW2 && div_rsp.done) dgain_q <= div_sat32;
    if (state_q == ST_MHI) lo_q <= mul_p;
    if (state_q == ST_MACC) r_q <= r_q + term;
    if (state_q == ST_SQR) ar_q <= ar_c;
    if (state_q == ST_FIN && sums_zero) begin
      mean_q <= '1;
      rms_q  <= '1;
      zden_q <= 1'b1;
    end
    if (state_q == ST_DWM && div_rsp.done) mean_q <= div_sat32;
    if (state_q == ST_SQW && sqrt_done) begin
      rms_q  <= sqrt_root;
      zden_q <= 1'b0;
    end
    if (state_q == ST_OUT && (!out_valid_q || !out_stall_i)) begin
      out_mean_q <= mean_q;
      out_rms_q  <= rms_q;
      out_zden_q <= zden_q;
    end
  end

  assign in_stall_o         = (state_q != ST_IDLE);
  assign cfg_ready_o        = 1'b1;
  assign out_valid_o        = out_valid_q;
  assign mean_dev_ratio_o   = out_mean_q;
  assign rms_ratio_o        = out_rms_q;
  assign zero_denominator_o = out_zden_q;

`ifndef ASSERT_OFF
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("block did not go busy after taking a sample");

  a_zero_den_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_denominator_o) |->
      (mean_dev_ratio_o == '1) && (rms_ratio_o == '1))
    else $error("zero denominator result without all-ones ratios");

  a_div_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_busy)
    else $error("divider restarted while busy");
`endif

endmodule

// ===== rtl/orem_mul.sv =====
// Shared registered 32 by 32 bit unsigned multiplier.
module orem_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== rtl/orem_div.sv =====
// Restoring bit-serial divider giving floor(num * 2^frac_steps / den) with overflow flag.
module orem_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  orem_pkg::div_req_t req_i,
  output orem_pkg::div_rsp_t rsp_o,
  output logic               busy_o
);

  logic [63:0]               num_q;
  logic [63:0]               den_q;
  logic [63:0]               rem_q;
  logic [63:0]               quo_q;
  logic                      ovf_q;
  logic                      busy_q;
  logic                      done_q;
  logic [orem_pkg::STEP_W-1:0] cnt_q;

  logic [64:0] trial;
  logic [64:0] diff;
  logic        fits;

  assign trial = {rem_q, num_q[63]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= orem_pkg::STEP_W'(64) + req_i.frac_steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - orem_pkg::STEP_W'(1);
      if (cnt_q == orem_pkg::STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= {num_q[62:0], 1'b0};
      rem_q <= fits ? diff[63:0] : trial[63:0];
      ovf_q <= ovf_q | quo_q[63];
      quo_q <= {quo_q[62:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.quo  = quo_q;
  assign busy_o     = busy_q;

endmodule

// ===== rtl/orem_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
module orem_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] x_q;
  logic [63:0] res_q;
  logic [63:0] bit_q;
  logic        busy_q;
  logic        done_q;

  logic [63:0] sum;
  logic        ge;

  assign sum = res_q + bit_q;
  assign ge  = x_q >= sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q && bit_q[0]) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      res_q <= '0;
      bit_q <= 64'd1 << 62;
    end else if (busy_q) begin
      if (ge) begin
        x_q   <= x_q - sum;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];

endmodule
